/* sv/chsq_pkg.sv */
package chsq_pkg;

  localparam int BIN_BITS_DEF      = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int SUM_BITS_DEF      = 48;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // Bits of one work-queue entry: {last, zero, den, diff}.
  function automatic int entry_bits(input int bin_bits);
    return 2 * bin_bits + 3;
  endfunction

endpackage

/* sv/chsq_fifo.sv */
module chsq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/chsq_front.sv */
module chsq_front #(
  parameter int BIN_BITS = chsq_pkg::BIN_BITS_DEF
) (
  input  logic                                     in_push,
  input  logic [BIN_BITS-1:0]                      in_first_bin,
  input  logic [BIN_BITS-1:0]                      in_second_bin,
  input  logic                                     in_last_pair,
  input  logic                                     q_full,
  output logic                                     q_push,
  output logic [chsq_pkg::entry_bits(BIN_BITS)-1:0] q_data
);
  import chsq_pkg::*;

  logic [BIN_BITS-1:0] diff;
  logic [BIN_BITS:0]   den;
  logic                zero;

  assign diff = (in_first_bin >= in_second_bin) ? (in_first_bin - in_second_bin)
                                                : (in_second_bin - in_first_bin);
  assign den  = {1'b0, in_first_bin} + {1'b0, in_second_bin};
  // only an all-zero pair has a zero denominator; its term is zero
  assign zero = ~|{in_first_bin, in_second_bin};

  assign q_push = in_push && !q_full;
  assign q_data = {in_last_pair, zero, den, diff};

endmodule

/* sv/chsq_back.sv */
module chsq_back #(
  parameter int BIN_BITS      = chsq_pkg::BIN_BITS_DEF,
  parameter int FRACTION_BITS = chsq_pkg::FRACTION_BITS_DEF,
  parameter int SUM_BITS      = chsq_pkg::SUM_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     q_empty,
  input  logic [chsq_pkg::entry_bits(BIN_BITS)-1:0] q_data,
  output logic                                     q_pop,
  input  logic                                     out_full,
  output logic                                     res_push,
  output logic [SUM_BITS-1:0]                      res_data
);
  import chsq_pkg::*;

  localparam int B  = BIN_BITS;
  localparam int Q  = BIN_BITS + FRACTION_BITS;
  localparam int RW = BIN_BITS + 2;
  localparam int PW = 2 * BIN_BITS;
  localparam int CW = $clog2(Q);
  localparam int AW = ((Q > SUM_BITS) ? Q : SUM_BITS) + 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SQUARE = 4'b0010,
    S_DIV    = 4'b0100,
    S_ACC    = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic                out_pend_r, out_pend_nxt;
  logic [B-1:0]        diff_r, diff_nxt;
  logic [B:0]          den_r, den_nxt;
  logic                zero_r, zero_nxt;
  logic                last_r, last_nxt;
  logic [RW-1:0]       rem_r, rem_nxt;
  logic [Q-1:0]        sh_r, sh_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [SUM_BITS-1:0] sum_r, sum_nxt;
  logic                sat_r, sat_nxt;

  logic [PW-1:0]       prod;
  logic [RW-1:0]       trial;
  logic                ge;
  logic [AW-1:0]       sum_ext;
  logic                over;

  assign prod    = PW'(diff_r) * PW'(diff_r);
  assign trial   = {rem_r[RW-2:0], sh_r[Q-1]};
  assign ge      = (trial >= RW'(den_r));
  assign sum_ext = AW'(sum_r) + AW'(sh_r);
  assign over    = (sum_ext > AW'({SUM_BITS{1'b1}}));

  assign q_pop    = (state_r == S_IDLE) && !out_pend_r && !q_empty;
  assign res_push = out_pend_r && !out_full;
  assign res_data = {sat_r, sum_r[SUM_BITS-1:1]};

  always_comb begin
    state_nxt    = state_r;
    out_pend_nxt = out_pend_r;
    diff_nxt     = diff_r;
    den_nxt      = den_r;
    zero_nxt     = zero_r;
    last_nxt     = last_r;
    rem_nxt      = rem_r;
    sh_nxt       = sh_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    sat_nxt      = sat_r;
    unique case (state_r)
      S_IDLE: begin
        if (res_push) begin
          out_pend_nxt = 1'b0;
          sum_nxt      = '0;
          sat_nxt      = 1'b0;
        end
        if (q_pop) begin
          {last_nxt, zero_nxt, den_nxt, diff_nxt} = q_data;
          state_nxt = S_SQUARE;
        end
      end
      S_SQUARE: begin
        // quotient stays below 2^Q, so the top bits of the dividend
        // already form a partial remainder below the denominator
        rem_nxt = RW'(prod >> B);
        sh_nxt  = Q'(prod[B-1:0]) << FRACTION_BITS;
        cnt_nxt = CW'(Q - 1);
        if (zero_r) begin
          sh_nxt    = '0;
          state_nxt = S_ACC;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = ge ? (trial - RW'(den_r)) : trial;
        sh_nxt  = {sh_r[Q-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (over) begin
          sum_nxt = '1;
          sat_nxt = 1'b1;
        end else begin
          sum_nxt = sum_ext[SUM_BITS-1:0];
        end
        out_pend_nxt = last_r;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_pend_r <= 1'b0;
      sum_r      <= '0;
      sat_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_pend_r <= out_pend_nxt;
      sum_r      <= sum_nxt;
      sat_r      <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    den_r  <= den_nxt;
    zero_r <= zero_nxt;
    last_r <= last_nxt;
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    cnt_r  <= cnt_nxt;
  end

`ifndef SYNTHESIS
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> (state_r == S_DIV || state_r == S_ACC))
    else $error("divider left to an unexpected state");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < RW'(den_r)))
    else $error("partial remainder not below denominator");

  a_sat_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && over) |=> (sum_r == {SUM_BITS{1'b1}} && sat_r))
    else $error("saturating add did not clamp");

  a_no_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_pend_r |-> !q_pop)
    else $error("new request taken while a result is pending");
`endif

endmodule

/* sv/chi_squared_histogram_distance_unit.sv */
// Chi-squared histogram distance. Each request on the input queue carries one bin of
// each histogram; the term (a-b)^2/(a+b) is formed by floor division with
// FRACTION_BITS fractional bits (an all-zero pair adds nothing) and summed into a
// saturating SUM_BITS accumulator. The request marked last_pair yields one result:
// half the sum in the same fixed-point format, plus a flag telling whether the sum
// saturated; the accumulator then clears. Each pair is squared, divided by the
// restoring divider in the back end at one quotient bit per cycle, and accumulated;
// an all-zero pair skips the divider. A new pair is taken only once the last is done;
// a last_pair first hands its result on, waiting while the result queue is full. A
// two-entry queue on each side keeps input and result ports running during division.
module chi_squared_histogram_distance_unit #(
  parameter int BIN_BITS      = chsq_pkg::BIN_BITS_DEF,
  parameter int FRACTION_BITS = chsq_pkg::FRACTION_BITS_DEF,
  parameter int SUM_BITS      = chsq_pkg::SUM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [BIN_BITS-1:0] in_first_bin,
  input  logic [BIN_BITS-1:0] in_second_bin,
  input  logic                in_last_pair,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [SUM_BITS-2:0] out_distance,
  output logic                out_saturated
);
  import chsq_pkg::*;

  localparam int EW = entry_bits(BIN_BITS);

  logic                q_push, q_full, q_pop, q_empty;
  logic [EW-1:0]       q_wdata, q_rdata;
  logic                res_push, res_full;
  logic [SUM_BITS-1:0] res_wdata, res_rdata;

  chsq_front #(
    .BIN_BITS(BIN_BITS)
  ) u_front (
    .in_push      (in_push),
    .in_first_bin (in_first_bin),
    .in_second_bin(in_second_bin),
    .in_last_pair (in_last_pair),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  chsq_fifo #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH_DEF)
  ) u_work_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty)
  );

  chsq_back #(
    .BIN_BITS     (BIN_BITS),
    .FRACTION_BITS(FRACTION_BITS),
    .SUM_BITS     (SUM_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_full(res_full),
    .res_push(res_push),
    .res_data(res_wdata)
  );

  chsq_fifo #(
    .WIDTH(SUM_BITS),
    .DEPTH(QUEUE_DEPTH_DEF)
  ) u_result_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_wdata),
    .full     (res_full),
    .pop      (out_pop),
    .pop_data (res_rdata),
    .empty    (out_empty)
  );

  assign in_full       = q_full;
  assign out_distance  = res_rdata[SUM_BITS-2:0];
  assign out_saturated = res_rdata[SUM_BITS-1];

endmodule
